// ----- rtl/wfp_pkg.sv -----
`timescale 1ns / 1ps

package wfp_pkg;

   // Parser phases of one file.
   typedef enum logic [2:0] {
      PH_FILEHDR,
      PH_CHUNKHDR,
      PH_SKIP,
      PH_FMT,
      PH_DRAIN
   } phase_type;

   // Four-character tags, first character in the lowest byte.
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;

   localparam logic [31:0] FMT_MIN  = 32'd16;
   localparam logic [4:0]  HDR_LEN  = 5'd12;

   // Outcome of one input word, handed from the parser to the output stage.
   typedef struct packed {
      logic        emit;
      logic        found;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
   } wfp_result_type;

   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
      tag_byte = tag[{idx, 3'b000} +: 8];
   endfunction

endpackage

// ----- rtl/riff_wav_format_parser.sv -----
`timescale 1ns / 1ps
// A result word is registered; it shows on the rsp side in the cycle after its deciding input word.
// Throughput: one input word per cycle; the parser state updates in the accepting cycle.
// Input is held off only while a result word waits and the rsp side is stalled.
// Reset is synchronous and active high; it returns the parser to the file header phase
// and empties the result register.

module riff_wav_format_parser
   import wfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] channels, [47:16] sample_rate, [63:48] bits_per_sample
   output logic        rsp_tuser    // found
);

   wfp_result_type result;
   logic           accept;
   logic           valid_ff, valid_in;
   logic [63:0]    data_ff;
   logic           found_ff;

   // The result register frees up in the same cycle its word is taken, so a
   // stream of input words keeps flowing while results drain.
   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   wfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (result)
   );

   always_comb begin
      if (accept) valid_in = result.emit;
      else        valid_in = valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   // Payload is loaded only with a new result word; it needs no reset.
   always_ff @(posedge clock) begin
      if (accept && result.emit) begin
         data_ff  <= {result.bits_per_sample, result.sample_rate, result.channels};
         found_ff <= result.found;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = found_ff;

endmodule

// ----- rtl/wfp_parser.sv -----
`timescale 1ns / 1ps

module wfp_parser
   import wfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   output wfp_result_type result
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] size_ff, size_in;
   logic [32:0] skip_ff, skip_in;
   logic        ok_ff, ok_in;
   logic [15:0] ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic        clear;

   always_ff @(posedge clock) begin
      if (reset || (step && clear)) begin
         phase_ff <= PH_FILEHDR;
         pos_ff   <= '0;
         id_ff    <= '0;
         size_ff  <= '0;
         skip_ff  <= '0;
         ok_ff    <= 1'b1;
         ch_ff    <= '0;
         rate_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         id_ff    <= id_in;
         size_ff  <= size_in;
         skip_ff  <= skip_in;
         ok_ff    <= ok_in;
         ch_ff    <= ch_in;
         rate_ff  <= rate_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      id_in    = id_ff;
      size_in  = size_ff;
      skip_in  = skip_ff;
      ok_in    = ok_ff;
      ch_in    = ch_ff;
      rate_in  = rate_ff;
      clear    = 1'b0;
      result   = '0;

      unique case (phase_ff)
         PH_FILEHDR: begin
            if (pos_ff < 5'd4) begin
               if (data_byte != tag_byte(TAG_RIFF, pos_ff[1:0])) ok_in = 1'b0;
            end else if (pos_ff >= 5'd8 && pos_ff < HDR_LEN) begin
               if (data_byte != tag_byte(TAG_WAVE, pos_ff[1:0])) ok_in = 1'b0;
            end
            if (pos_ff >= HDR_LEN - 5'd1) begin
               if (!ok_in || last_byte) begin
                  result.emit = 1'b1;
               end else begin
                  phase_in = PH_CHUNKHDR;
                  pos_in   = '0;
               end
            end else if (last_byte) begin
               result.emit = 1'b1;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end
         PH_CHUNKHDR: begin
            if (pos_ff < 5'd4) id_in = {data_byte, id_ff[31:8]};
            else               size_in = {data_byte, size_ff[31:8]};
            if (last_byte) begin
               result.emit = 1'b1;
            end else if (pos_ff >= 5'd7) begin
               pos_in = '0;
               if (id_in == TAG_FMT && size_in >= FMT_MIN) begin
                  phase_in = PH_FMT;
                  ch_in    = '0;
                  rate_in  = '0;
               end else begin
                  // Body length plus the pad byte of an odd-sized chunk.
                  skip_in  = {1'b0, size_in} + {32'd0, size_in[0]};
                  phase_in = (skip_in == '0) ? PH_CHUNKHDR : PH_SKIP;
               end
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end
         PH_SKIP: begin
            if (last_byte) begin
               result.emit = 1'b1;
            end else begin
               if (skip_ff != '0) skip_in = skip_ff - 33'd1;
               if (skip_in == '0) begin
                  phase_in = PH_CHUNKHDR;
                  pos_in   = '0;
               end
            end
         end
         PH_FMT: begin
            if (pos_ff == 5'd2) begin
               ch_in = {8'd0, data_byte};
            end else if (pos_ff == 5'd3) begin
               ch_in = ch_ff | {data_byte, 8'd0};
            end else if (pos_ff >= 5'd4 && pos_ff < 5'd8) begin
               rate_in = rate_ff | ({24'd0, data_byte} << {pos_ff[1:0], 3'b000});
            end else if (pos_ff == 5'd14) begin
               id_in = {24'd0, data_byte};
            end
            if (pos_ff >= 5'd15) begin
               result.emit            = 1'b1;
               result.found           = 1'b1;
               result.channels        = ch_ff;
               result.sample_rate     = rate_ff;
               result.bits_per_sample = {data_byte, id_ff[7:0]};
            end else if (last_byte) begin
               result.emit = 1'b1;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end
         PH_DRAIN: begin
            if (last_byte) clear = 1'b1;
         end
         default: begin
            if (last_byte) clear = 1'b1;
         end
      endcase

      // Once the outcome is out, the rest of the file is drained.
      if (result.emit) begin
         if (last_byte) clear = 1'b1;
         else           phase_in = PH_DRAIN;
      end
   end

endmodule

// ----- rtl/wfp_checker.sv -----
`timescale 1ns / 1ps

module wfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A not-found result carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("not-found result with nonzero fields");

   // A new result word only follows an accepted input word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result word without an input word");

   // With the result register empty, input is always ready to be taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input held off with empty result register");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

endmodule

bind riff_wav_format_parser wfp_checker u_wfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_riff_wav_format_parser.sv -----
`timescale 1ns / 1ps

module tb_riff_wav_format_parser;
   import wfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 6;

   // One parsed outcome, as carried by a result word.
   typedef struct packed {
      logic        found;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
   } wav_fmt_info_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [15:0] channels, [47:16] sample_rate, [63:48] bits_per_sample
   logic        rsp_tuser;           // found

   riff_wav_format_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Outcomes the parser has committed to but not yet delivered.
   wav_fmt_info_type fmt_expect_q[$];
   // Bytes of the file being built for the next transfer.
   logic [7:0]    wav_bytes[$];

   bit idling_on = 1'b1;
   int mismatch_count = 0;
   int files_sent = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int found_count = 0;

   // Shadow copy of the parser state.
   phase_type   wav_phase;
   logic [4:0]  hdr_pos;
   logic [31:0] id_shift;
   logic [31:0] size_shift;
   logic [32:0] skip_left;
   logic        hdr_good;
   logic [15:0] fmt_channels;
   logic [31:0] fmt_rate;
   logic [7:0]  bits_low;

   task automatic clear_parser();
      wav_phase    = PH_FILEHDR;
      hdr_pos      = '0;
      id_shift     = '0;
      size_shift   = '0;
      skip_left    = '0;
      hdr_good     = 1'b1;
      fmt_channels = '0;
      fmt_rate     = '0;
      bits_low     = '0;
   endtask

   task automatic record_outcome(input logic ok, input logic [15:0] ch, input logic [31:0] rate,
                                 input logic [15:0] bits, input logic last);
      wav_fmt_info_type info;
      info.found           = ok;
      info.channels        = ok ? ch : 16'h0;
      info.sample_rate     = ok ? rate : 32'h0;
      info.bits_per_sample = ok ? bits : 16'h0;
      fmt_expect_q.push_back(info);
      if (ok) found_count++;
      if (last) clear_parser();
      else wav_phase = PH_DRAIN;
   endtask

   // Advances the shadow parser by one accepted byte and queues any outcome it decides.
   task automatic parse_wav_byte(input logic [7:0] b, input logic last);
      logic [31:0] tag_word;
      case (wav_phase)
         PH_FILEHDR: begin
            // Bytes 4 to 7 carry the file size and are not checked.
            tag_word = (hdr_pos < 5'd4) ? TAG_RIFF : TAG_WAVE;
            tag_word = tag_word >> (8 * hdr_pos[1:0]);
            if ((hdr_pos < 5'd4 || hdr_pos >= 5'd8) && tag_word[7:0] != b) hdr_good = 1'b0;
            if (hdr_pos + 5'd1 >= HDR_LEN) begin
               if (!hdr_good || last) begin
                  record_outcome(1'b0, 16'h0, 32'h0, 16'h0, last);
               end else begin
                  wav_phase = PH_CHUNKHDR;
                  hdr_pos   = '0;
               end
            end else if (last) begin
               record_outcome(1'b0, 16'h0, 32'h0, 16'h0, 1'b1);
            end else begin
               hdr_pos = hdr_pos + 5'd1;
            end
         end
         PH_CHUNKHDR: begin
            if (hdr_pos < 5'd4) id_shift = {b, id_shift[31:8]};
            else size_shift = {b, size_shift[31:8]};
            if (last) begin
               record_outcome(1'b0, 16'h0, 32'h0, 16'h0, 1'b1);
            end else if (hdr_pos >= 5'd7) begin
               hdr_pos = '0;
               if (id_shift == TAG_FMT && size_shift >= FMT_MIN) begin
                  wav_phase    = PH_FMT;
                  fmt_channels = '0;
                  fmt_rate     = '0;
               end else begin
                  // Odd bodies carry a pad byte; 33 bits hold the largest size plus pad.
                  skip_left = {1'b0, size_shift} + 33'(size_shift[0]);
                  wav_phase = (skip_left == '0) ? PH_CHUNKHDR : PH_SKIP;
               end
            end else begin
               hdr_pos = hdr_pos + 5'd1;
            end
         end
         PH_SKIP: begin
            if (last) begin
               record_outcome(1'b0, 16'h0, 32'h0, 16'h0, 1'b1);
            end else begin
               if (skip_left != '0) skip_left = skip_left - 33'd1;
               if (skip_left == '0) begin
                  wav_phase = PH_CHUNKHDR;
                  hdr_pos   = '0;
               end
            end
         end
         PH_FMT: begin
            case (hdr_pos)
               5'd2:  fmt_channels[7:0]  = b;
               5'd3:  fmt_channels[15:8] = b;
               5'd4:  fmt_rate[7:0]      = b;
               5'd5:  fmt_rate[15:8]     = b;
               5'd6:  fmt_rate[23:16]    = b;
               5'd7:  fmt_rate[31:24]    = b;
               5'd14: bits_low           = b;
               default: ;
            endcase
            if (hdr_pos >= 5'd15) begin
               record_outcome(1'b1, fmt_channels, fmt_rate, {b, bits_low}, last);
            end else if (last) begin
               record_outcome(1'b0, 16'h0, 32'h0, 16'h0, 1'b1);
            end else begin
               hdr_pos = hdr_pos + 5'd1;
            end
         end
         default: begin
            // The outcome is out; everything up to the end of the file is dropped.
            if (last) clear_parser();
         end
      endcase
   endtask

   // Sends one input word, with an occasional idle burst in front of it.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      parse_wav_byte(b, last);
   endtask

   // Sends the built file with the last flag on its final byte, then empties the buffer.
   task automatic send_wav();
      for (int i = 0; i < wav_bytes.size(); i++) send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
      if (wav_bytes.size() != 0) files_sent++;
      wav_bytes.delete();
   endtask

   // Always lets at least one edge pass, so the next word is driven in a later time step.
   task automatic hold_off_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (fmt_expect_q.size() != 0);
   endtask

   task automatic push_word(input logic [31:0] v);
      for (int k = 0; k < 4; k++) begin
         wav_bytes.push_back(v[7:0]);
         v = v >> 8;
      end
   endtask

   task automatic push_chunk(input logic [31:0] id, input logic [31:0] size, input int body_len);
      push_word(id);
      push_word(size);
      repeat (body_len) wav_bytes.push_back(8'($urandom));
   endtask

   // Sixteen bytes of a format body; the format tag, byte rate and block align fields are random.
   task automatic push_fmt_body(input logic [15:0] ch, input logic [31:0] rate,
                                input logic [15:0] bits);
      wav_bytes.push_back(8'($urandom));
      wav_bytes.push_back(8'($urandom));
      wav_bytes.push_back(ch[7:0]);
      wav_bytes.push_back(ch[15:8]);
      push_word(rate);
      repeat (6) wav_bytes.push_back(8'($urandom));
      wav_bytes.push_back(bits[7:0]);
      wav_bytes.push_back(bits[15:8]);
   endtask

   task automatic push_file_header();
      push_word(TAG_RIFF);
      push_word($urandom);
      push_word(TAG_WAVE);
   endtask

   // Builds a mostly well-formed file with random content, then sometimes breaks it.
   task automatic build_random_wav();
      int          n_pre;
      int          mode;
      int          cut;
      int          idx;
      logic [31:0] size;
      logic [31:0] id;
      push_file_header();
      n_pre = $urandom_range(0, 3);
      repeat (n_pre) begin
         if ($urandom_range(0, 3) == 0) begin
            id   = TAG_FMT;
            size = $urandom_range(0, 15);
         end else begin
            id   = $urandom;
            size = $urandom_range(0, 9);
         end
         push_chunk(id, size, size + size[0]);
      end
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
         // A huge chunk that the file ends inside of.
         push_chunk($urandom, $urandom, $urandom_range(0, 6));
      end else if (mode < 20) begin
         // No usable format chunk at all.
         push_chunk($urandom, 32'd1, 2);
      end else begin
         size = ($urandom_range(0, 5) == 0) ? ($urandom | 32'h10) : $urandom_range(16, 24);
         push_chunk(TAG_FMT, size, 0);
         push_fmt_body($urandom, $urandom, $urandom);
         repeat ($urandom_range(0, 4)) wav_bytes.push_back(8'($urandom));
      end
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
         idx = $urandom_range(0, 11);
         wav_bytes[idx] = wav_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (mode < 25) begin
         cut = $urandom_range(1, wav_bytes.size());
         while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
      end else if (mode < 30) begin
         wav_bytes.delete();
         repeat ($urandom_range(1, 20)) wav_bytes.push_back(8'($urandom));
      end
   endtask

   // One-byte file, a corrupt tag with trailing bytes, and a header that is all the file has.
   task automatic test_header_edges();
      wav_bytes.push_back(8'h52);
      send_wav();
      push_word(32'h5849_4952);
      push_word(32'hFFFF_FFFF);
      push_word(TAG_WAVE);
      repeat (3) wav_bytes.push_back(8'hFF);
      send_wav();
      push_word(TAG_RIFF);
      push_word(32'h0000_0000);
      push_word(TAG_WAVE);
      send_wav();
   endtask

   // Zero-size chunk, short format chunk, then a format chunk with extreme fields and trailing bytes.
   task automatic test_fmt_extremes();
      push_file_header();
      push_chunk(32'h6174_6164, 32'd0, 0);
      push_chunk(TAG_FMT, 32'd3, 4);
      push_chunk(TAG_FMT, 32'hFFFF_FFFF, 0);
      push_fmt_body(16'hFFFF, 32'h0000_0000, 16'hFFFF);
      repeat (2) wav_bytes.push_back(8'h00);
      send_wav();
   endtask

   // Files that end inside the format fields, a huge skipped body and a chunk header.
   task automatic test_truncations();
      push_file_header();
      push_chunk(TAG_FMT, 32'd16, 0);
      push_fmt_body(16'h0002, 32'hFFFF_FFFF, 16'h0010);
      repeat (4) void'(wav_bytes.pop_back());
      send_wav();
      push_file_header();
      push_chunk(32'h0, 32'hFFFF_FFFF, 3);
      send_wav();
      push_file_header();
      push_word(TAG_FMT);
      wav_bytes.push_back(8'h10);
      send_wav();
   endtask

   task automatic test_random_files(input int byte_budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < byte_budget) begin
         build_random_wav();
         send_wav();
      end
   endtask

   // The sender stops after each file until its outcome has been delivered.
   task automatic test_pressure_pause();
      repeat (3) begin
         build_random_wav();
         send_wav();
         hold_off_until_drained();
      end
   endtask

   // Receiver side: random stall bursts while idling is enabled.
   int rsp_stall_left = 0;
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each delivered result word is matched against the oldest pending outcome.
   always @(posedge clock) begin : check_rsp
      wav_fmt_info_type seen;
      wav_fmt_info_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.found           = rsp_tuser;
         seen.channels        = rsp_tdata[15:0];
         seen.sample_rate     = rsp_tdata[47:16];
         seen.bits_per_sample = rsp_tdata[63:48];
         results_seen++;
         if (fmt_expect_q.size() == 0) begin
            $error("unexpected result word: found %0b channels %0h rate %0h bits %0h",
                   seen.found, seen.channels, seen.sample_rate, seen.bits_per_sample);
            mismatch_count++;
         end else begin
            want = fmt_expect_q.pop_front();
            if (seen.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, seen.found);
               mismatch_count++;
            end
            if (seen.channels !== want.channels) begin
               $error("channels: expected %0h, got %0h", want.channels, seen.channels);
               mismatch_count++;
            end
            if (seen.sample_rate !== want.sample_rate) begin
               $error("sample_rate: expected %0h, got %0h", want.sample_rate, seen.sample_rate);
               mismatch_count++;
            end
            if (seen.bits_per_sample !== want.bits_per_sample) begin
               $error("bits_per_sample: expected %0h, got %0h",
                      want.bits_per_sample, seen.bits_per_sample);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run when no word moves on either side for too long.
   int stuck_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d outcomes pending.", fmt_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      clear_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_header_edges();
      test_fmt_extremes();
      test_truncations();
      test_random_files(1300);
      test_pressure_pause();
      idling_on = 1'b0;
      test_random_files(350);
      hold_off_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d files in %0d bytes; checked %0d outcomes, %0d with a format chunk.",
               files_sent, bytes_sent, results_seen, found_count);
      $display("Headers, chunk walking, truncation and trailing bytes ran under random stalls.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
